/* rtl/mad_pkg.sv */
// Shared types, widths and constants for the moving average deviation unit.
package mad_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int SAMPLE_W  = 16;
  localparam int AVG_W     = 16;
  localparam int DEV_W     = 17;
  localparam int SUM_W     = 22;
  localparam int WLEN_W    = 7;
  localparam int STEP_W    = $clog2(SUM_W);

  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd64;

  // Input action codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Saturation bounds of the average
  localparam logic [AVG_W-1:0] AVG_MAX = 16'h7FFF;
  localparam logic [AVG_W-1:0] AVG_MIN = 16'h8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // input beat taken
    logic upd;     // ring and sum update, divider load
    logic step;    // one divider iteration
    logic finish;  // result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/mad_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mad_ctrl.sv */
// Controller state machine: sequences read, update, divide and result load; a clear does the load only.
module mad_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_stall,
  input  mad_pkg::sts_t sts,
  output mad_pkg::cmd_t cmd
);

  import mad_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_CLEAR) ? ST_FIN : ST_READ;
        end
      end
      ST_READ: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/mad_dp.sv */
// Datapath: sample ring, running sum, radix-2 divider and output register.
module mad_dp #(
  parameter int DEPTH = mad_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mad_pkg::cmd_t                 cmd,
  output mad_pkg::sts_t                 sts,
  input  logic                          in_action,
  input  logic signed [mad_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          cfg_we,
  input  logic [mad_pkg::WLEN_W-1:0]    cfg_wlen,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [mad_pkg::AVG_W-1:0] out_average,
  output logic signed [mad_pkg::DEV_W-1:0] out_deviation
);

  import mad_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((1 << (AVG_W - 1)) - 1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(1 << (AVG_W - 1));

  // Control state
  logic [WLEN_W-1:0] wlen_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              filled_r, filled_nxt;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;

  // Payload registers
  logic                      action_r;
  logic [SAMPLE_W-1:0]       sample_r;
  logic [CNT_W-1:0]          div_r;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic [SUM_W-1:0]          quo_r;
  logic                      neg_r;
  logic [AVG_W-1:0]          avg_r;
  logic [DEV_W-1:0]          dev_r;

  logic [SAMPLE_W-1:0] rd_data;
  logic [SUM_W-1:0]    old_ext;
  logic [CMP_W-1:0]    wl_ext, len_cmp;
  logic [CNT_W-1:0]    len_eff, idx_inc, count;
  logic                wrap;
  logic [SUM_W-1:0]    mag;
  logic [CNT_W:0]      rem_sh, rem_sub;
  logic                ge;
  logic [SUM_W-1:0]    q_neg;
  logic [AVG_W-1:0]    avg_fin;
  logic [DEV_W-1:0]    dev_fin;
  logic                out_free;

  // Sample ring
  mad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (idx_r),
    .wdata (sample_r),
    .re    (cmd.load),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // Window length clip: zero acts as one, capped at the ring depth
  always_comb begin
    wl_ext = CMP_W'(wlen_r);
    if (wl_ext == '0) begin
      len_cmp = CMP_W'(1);
    end else if (wl_ext > DEPTH_C) begin
      len_cmp = DEPTH_C;
    end else begin
      len_cmp = wl_ext;
    end
    len_eff = len_cmp[CNT_W-1:0];
  end

  // Ring and sum update; the overwritten slot counts as zero before fill
  always_comb begin
    old_ext    = filled_r ? {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data} : '0;
    sum_nxt    = sum_r - old_ext
               + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
    idx_inc    = CNT_W'(idx_r) + CNT_W'(1);
    count      = filled_r ? len_eff : idx_inc;
    wrap       = (idx_inc >= len_eff);
    idx_nxt    = wrap ? '0 : idx_inc[IDX_W-1:0];
    filled_nxt = filled_r | wrap;
    mag        = sum_nxt[SUM_W-1] ? (~sum_nxt + SUM_W'(1)) : sum_nxt;
  end

  // Restoring divider step, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, div_r});
    rem_sub = rem_sh - {1'b0, div_r};
    rem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  end

  // Sign restore, saturation and deviation
  always_comb begin
    q_neg = ~quo_r + SUM_W'(1);
    if (neg_r) begin
      avg_fin = (quo_r > NEG_LIM) ? AVG_MIN : q_neg[AVG_W-1:0];
    end else begin
      avg_fin = (quo_r > POS_LIM) ? AVG_MAX : quo_r[AVG_W-1:0];
    end
    dev_fin = {sample_r[SAMPLE_W-1], sample_r} - {avg_fin[AVG_W-1], avg_fin};
  end

  assign out_free = !out_valid_r || !out_stall;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= WLEN_RST;
      idx_r       <= '0;
      sum_r       <= '0;
      filled_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wlen_r <= cfg_wlen;
      end
      if (cmd.upd) begin
        idx_r    <= idx_nxt;
        sum_r    <= sum_nxt;
        filled_r <= filled_nxt;
        step_r   <= '0;
      end else if (cmd.step) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.finish && action_r == ACT_CLEAR) begin
        idx_r    <= '0;
        sum_r    <= '0;
        filled_r <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      sample_r <= in_sample;
    end
    if (cmd.upd) begin
      div_r <= count;
      rem_r <= '0;
      quo_r <= mag;
      neg_r <= sum_nxt[SUM_W-1];
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
    if (cmd.finish) begin
      if (action_r == ACT_CLEAR) begin
        avg_r <= '0;
        dev_r <= '0;
      end else begin
        avg_r <= avg_fin;
        dev_r <= dev_fin;
      end
    end
  end

  assign sts.div_last  = (step_r == STEP_W'(SUM_W - 1));
  assign sts.out_free  = out_free;
  assign out_valid     = out_valid_r;
  assign out_average   = avg_r;
  assign out_deviation = dev_r;

endmodule

/* rtl/moving_average_deviation_unit.sv */
// A push beat's result is valid after the ring read, the update, the divider
// iterations (one quotient bit per cycle of the 22-bit sum) and the result load;
// a clear beat goes straight to the result load. A new beat is taken only after
// the previous one is finished. A held result stalls only the final step.
// Reset (synchronous, rst_n low): empty window, window length 64, no result pending;
// the sample ring is not cleared and is ready at once.
module moving_average_deviation_unit #(
  parameter int DEPTH = mad_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [mad_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mad_pkg::AVG_W-1:0]    out_average,
  output logic signed [mad_pkg::DEV_W-1:0]    out_deviation,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mad_pkg::WLEN_W-1:0]          cfg_window_len
);

  import mad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Window length register is always writable
  assign cfg_ready = 1'b1;

  mad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mad_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_sample     (in_sample),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_wlen      (cfg_window_len),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_average   (out_average),
    .out_deviation (out_deviation)
  );

endmodule
